// ===== src/window_normal_cull_mask_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the window normal cull mask block.
// Each macro expands to a concurrent assertion, or to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef WINDOW_NORMAL_CULL_MASK_MACROS_SVH
`define WINDOW_NORMAL_CULL_MASK_MACROS_SVH
`ifndef SYNTH
`define WNC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define WNC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define WNC_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define WNC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== src/wncm_pkg.sv =====
// ----------------------------------------------------------------------------
// wncm_pkg
// Types, constants and command structures shared by the cull mask block.
// ----------------------------------------------------------------------------
package wncm_pkg;

	localparam int MAX_HALF   = 3;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int LINE_ROWS  = 2 * MAX_HALF + 1;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int LROW_W     = $clog2(LINE_ROWS);
	localparam int ADDR_W     = $clog2(LINE_ROWS * MAX_WIDTH);
	localparam int HALF_W     = $clog2(MAX_HALF + 1);
	localparam int WIN_W      = $clog2(LINE_ROWS + 1);

	localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_HALF_WINDOW    = 3'd2;
	localparam logic [2:0] REG_COS_LIMIT      = 3'd3;
	localparam logic [2:0] REG_RESIDUAL_LIMIT = 3'd4;

	typedef struct packed {
		logic               frame_start;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
	} in_item_t;

	typedef struct packed {
		logic [9:0] center_row;
		logic [9:0] center_col;
		logic       culled;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [23:0] data;
	} cfg_beat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic               write;      // store the input pixel
		logic [ADDR_W-1:0]  wr_addr;
		logic               seed_rd;    // read the window center
		logic               nb_rd;      // read one neighbor
		logic [ADDR_W-1:0]  rd_addr;
		logic               nb_eval;    // evaluate latched neighbor
		logic               clear;      // start a new decision
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cull;
		logic seed_zero;
	} dp_stat_t;

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [LROW_W-1:0] lrow,
			input logic [COL_W-1:0] col);
		logic [ADDR_W+LROW_W-1:0] prod;
		prod = (ADDR_W + LROW_W)'(lrow) * (ADDR_W + LROW_W)'(MAX_WIDTH);
		return ADDR_W'(prod) + ADDR_W'(col);
	endfunction

endpackage

// ===== src/wncm_datapath.sv =====
// ----------------------------------------------------------------------------
// wncm_datapath
// Line stores and the neighbor test unit: one window pixel per cycle,
// dot and residual products registered before the compare.
// ----------------------------------------------------------------------------
module wncm_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wncm_pkg::dp_cmd_t      cmd,
	input  wncm_pkg::in_item_t     pix,
	input  logic signed [15:0]     cos_limit,
	input  logic [23:0]            residual_limit,
	output wncm_pkg::dp_stat_t     stat
);
	import wncm_pkg::*;

	localparam int DEPTH = LINE_ROWS * MAX_WIDTH;

	logic [119:0] mem [DEPTH];
	logic [119:0] rd_q;
	logic         seed_v_s1, nb_v_s1, nb_v_s2;

	logic signed [23:0] spx_q, spy_q, spz_q;
	logic signed [15:0] snx_q, sny_q, snz_q;
	logic signed [31:0] px, py, pz, tx, ty, tz;
	logic signed [24:0] dx, dy, dz;
	logic signed [15:0] nx, ny, nz;
	logic signed [40:0] rx_s2, ry_s2, rz_s2;
	logic signed [31:0] ax_s2, ay_s2, az_s2;
	logic signed [43:0] dot, res, res_abs;
	logic signed [43:0] cos_q28, res_lim;
	logic               cull_q, zero_q;

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[cmd.wr_addr] <= {pix.pos_x, pix.pos_y, pix.pos_z, pix.norm_x, pix.norm_y,
				pix.norm_z};
		end
		rd_q <= mem[cmd.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_v_s1 <= 1'b0;
			nb_v_s1   <= 1'b0;
			nb_v_s2   <= 1'b0;
		end else begin
			seed_v_s1 <= cmd.seed_rd;
			nb_v_s1   <= cmd.nb_rd;
			nb_v_s2   <= nb_v_s1;
		end
	end

	assign dx = 25'(spx_q) - 25'(signed'(rd_q[119:96]));
	assign dy = 25'(spy_q) - 25'(signed'(rd_q[95:72]));
	assign dz = 25'(spz_q) - 25'(signed'(rd_q[71:48]));
	assign nx = signed'(rd_q[47:32]);
	assign ny = signed'(rd_q[31:16]);
	assign nz = signed'(rd_q[15:0]);

	always_ff @(posedge clk) begin
		if (seed_v_s1) begin
			spx_q <= signed'(rd_q[119:96]);
			spy_q <= signed'(rd_q[95:72]);
			spz_q <= signed'(rd_q[71:48]);
			snx_q <= nx;
			sny_q <= ny;
			snz_q <= nz;
		end
		rx_s2 <= 41'(snx_q) * 41'(dx);
		ry_s2 <= 41'(sny_q) * 41'(dy);
		rz_s2 <= 41'(snz_q) * 41'(dz);
		ax_s2 <= 32'(snx_q) * 32'(nx);
		ay_s2 <= 32'(sny_q) * 32'(ny);
		az_s2 <= 32'(snz_q) * 32'(nz);
	end

	assign px = 32'(signed'(rd_q[119:96]));
	assign py = 32'(signed'(rd_q[95:72]));
	assign pz = 32'(signed'(rd_q[71:48]));
	assign tx = px;
	assign ty = py;
	assign tz = pz;

	assign dot     = 44'(ax_s2) + 44'(ay_s2) + 44'(az_s2);
	assign res     = 44'(rx_s2) + 44'(ry_s2) + 44'(rz_s2);
	assign res_abs = res[43] ? -res : res;
	assign cos_q28 = 44'(cos_limit) <<< 14;
	assign res_lim = 44'({20'd0, residual_limit}) << 14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cull_q <= 1'b0;
			zero_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				cull_q <= 1'b0;
			end else if (nb_v_s2 && cmd.nb_eval) begin
				if ((dot < (44'sd1 <<< 28) && dot < cos_q28) || res_abs > res_lim) begin
					cull_q <= 1'b1;
				end
			end
			if (seed_v_s1) begin
				zero_q <= (tx == 32'sd0) && (ty == 32'sd0) && (tz == 32'sd0);
			end
		end
	end

	assign stat.cull      = cull_q;
	assign stat.seed_zero = zero_q;

	`include "window_normal_cull_mask_macros.svh"
	`WNC_ASSERT_NEXT(a_clear_resets, clk, arst_n, cmd.clear, !cull_q, "cull flag not cleared")
	`WNC_ASSERT_NEXT(a_nb_pipe, clk, arst_n, nb_v_s1, nb_v_s2, "neighbor stage lost")
	`WNC_ASSERT_IMPL(a_rd_excl, clk, arst_n, !(cmd.seed_rd && cmd.nb_rd), "two reads at once")
endmodule

// ===== src/wncm_ctrl.sv =====
// ----------------------------------------------------------------------------
// wncm_ctrl
// Raster tracking, window sequencing and handshakes of the cull mask block.
// ----------------------------------------------------------------------------
module wncm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 frame_start,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wncm_pkg::out_item_t  out_item,
	input  logic [10:0]          frame_width,
	input  logic [10:0]          frame_height,
	input  logic [1:0]           half_window,
	output wncm_pkg::dp_cmd_t    cmd,
	input  wncm_pkg::dp_stat_t   stat
);
	import wncm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SEED = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]        state_q;
	logic [ROW_W-1:0]  row_q, cr_q;
	logic [COL_W-1:0]  col_q, cc_q;
	logic [LROW_W-1:0] lrow_q;
	logic [LROW_W-1:0] base_lrow_q, nb_lrow_q;
	logic [COL_W-1:0]  base_col_q;
	logic [WIN_W-1:0]  wr_q, wc_q;
	logic [2:0]        drain_q;
	logic [WIN_W-1:0]  side_q;
	out_item_t         out_q;
	logic              out_v_q;

	logic [11:0]       w, hgt;
	logic [HALF_W-1:0] h;
	logic [ROW_W-1:0]  r0, r1, rr;
	logic [COL_W-1:0]  c0, c1, cn;
	logic [11:0]       c0x, r0x, rwr;
	logic [LROW_W-1:0] lr0, lr_c, lr_b, lnext;
	logic [3:0]        h2;
	logic              accept, emit, load_out;

	assign w   = (frame_width == 11'd0) ? 12'd1 :
		(frame_width > 11'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : 12'(frame_width);
	assign hgt = (frame_height == 11'd0) ? 12'd1 :
		(frame_height > 11'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) : 12'(frame_height);
	assign h   = (32'(half_window) > MAX_HALF) ? HALF_W'(MAX_HALF) : HALF_W'(half_window);
	assign h2  = {1'b0, h, 1'b0};

	function automatic logic [LROW_W-1:0] lsub(input logic [LROW_W-1:0] a,
			input logic [3:0] b);
		logic [4:0] t;
		t = 5'(a) + 5'(LINE_ROWS) - 5'(b);
		return (t >= 5'(LINE_ROWS)) ? LROW_W'(t - 5'(LINE_ROWS)) : LROW_W'(t);
	endfunction

	function automatic logic [LROW_W-1:0] linc(input logic [LROW_W-1:0] a);
		return (32'(a) == LINE_ROWS - 1) ? '0 : a + 1'b1;
	endfunction

	// Raster position for the incoming pixel.
	always_comb begin
		r0 = frame_start ? '0 : row_q;
		c0 = frame_start ? '0 : col_q;
		lr0 = frame_start ? '0 : lrow_q;
		c0x = 12'(c0);
		r1 = r0;
		c1 = c0;
		lr_c = lr0;
		if (c0x >= w) begin
			c1 = '0;
			r1 = r0 + 1'b1;
			lr_c = linc(lr0);
		end
		r0x = {1'b0, r1} + ((c0x >= w) && (r0 == '1) ? 12'h400 : 12'h0);
		if (r0x >= hgt) begin
			r1 = '0;
			lr_c = '0;
		end
		lr_b = lsub(lr_c, h2);
		rr = r1 - ROW_W'(h);
		cn = c1 - COL_W'(h);
	end

	assign accept = in_valid && in_ready;
	assign emit   = (12'(r1) >= 12'(h2)) && (12'(c1) >= 12'(h2));
	assign in_ready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_DONE) && (!out_v_q || out_ready);
	assign lnext = linc(lr_c);
	assign rwr = 12'(r1) + 12'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			col_q <= '0;
			lrow_q <= '0;
			out_v_q <= 1'b0;
			wr_q <= '0;
			wc_q <= '0;
			drain_q <= '0;
		end else begin
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (12'(c1) + 12'd1 >= w) begin
							col_q <= '0;
							if (rwr >= hgt) begin
								row_q <= '0;
								lrow_q <= '0;
							end else begin
								row_q <= r1 + 1'b1;
								lrow_q <= lnext;
							end
						end else begin
							col_q <= c1 + 1'b1;
							row_q <= r1;
							lrow_q <= lr_c;
						end
						if (emit) begin
							state_q <= ST_SEED;
						end
					end
				end
				ST_SEED: begin
					wr_q <= '0;
					wc_q <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (32'(wc_q) == 2 * 32'(h)) begin
						wc_q <= '0;
						if (32'(wr_q) == 2 * 32'(h)) begin
							drain_q <= 3'd3;
							state_q <= ST_DRAIN;
						end else begin
							wr_q <= wr_q + 1'b1;
						end
					end else begin
						wc_q <= wc_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q - 1'b1;
					if (drain_q == 3'd1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Window geometry of the decision under way.
	always_ff @(posedge clk) begin
		if (accept) begin
			cr_q <= rr;
			cc_q <= cn;
			base_lrow_q <= lr_b;
			base_col_q <= c1 - COL_W'(h2);
			nb_lrow_q <= lr_b;
		end else if (state_q == ST_SCAN && 32'(wc_q) == 2 * 32'(h)) begin
			nb_lrow_q <= linc(nb_lrow_q);
		end
		if (load_out) begin
			out_q.center_row <= cr_q;
			out_q.center_col <= cc_q;
			out_q.culled <= stat.seed_zero || stat.cull;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.write   = accept;
		cmd.wr_addr = slot_addr(lr_c, c1);
		cmd.clear   = accept;
		cmd.nb_eval = 1'b1;
		if (state_q == ST_SEED) begin
			cmd.seed_rd = 1'b1;
			cmd.rd_addr = slot_addr(lsub(lsub(base_lrow_q, 4'd0), 4'(LINE_ROWS) - 4'(h)),
				cc_q);
		end else if (state_q == ST_SCAN) begin
			cmd.nb_rd = 1'b1;
			cmd.rd_addr = slot_addr(nb_lrow_q, base_col_q + COL_W'(wc_q));
		end
	end

	assign side_q    = WIN_W'(h2) + 1'b1;
	assign out_valid = out_v_q;
	assign out_item  = out_q;

	`include "window_normal_cull_mask_macros.svh"
	`WNC_ASSERT_IMPL(a_busy_no_ready, clk, arst_n, (state_q == ST_IDLE) || !in_ready,
		"ready while busy")
	`WNC_ASSERT_IMPL(a_scan_bound, clk, arst_n, (state_q != ST_SCAN) || (wc_q < side_q),
		"window column out of range")
	`WNC_ASSERT_NEXT(a_done_emit, clk, arst_n, load_out, out_v_q,
		"decision not presented")
endmodule

// ===== src/window_normal_cull_mask.sv =====
// ----------------------------------------------------------------------------
// window_normal_cull_mask
// Culls organized point map pixels at the origin or whose window holds a
// neighbor with too wide a normal angle or too large a plane offset.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    in_item_t, one pixel
// out       output     out_valid/out_ready  out_item_t, one decision
// cfg       input      cfg_valid/cfg_ready  cfg_beat_t, index and data
//
// A pixel with no decision leaves the input ready for the next one. A pixel
// that completes a window holds off input while the window is read, one
// neighbor per cycle through one store read port and one multiply stage.
// Reset clears the raster position and registers; the line stores hold
// no reset. A stalled output beat lets input beats in until the next
// decision is ready, which then waits for the output register to free up.
// ----------------------------------------------------------------------------
module window_normal_cull_mask (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wncm_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output wncm_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  wncm_pkg::cfg_beat_t cfg_data
);
	import wncm_pkg::*;

	logic [10:0]        frame_width_q, frame_height_q;
	logic [1:0]         half_window_q;
	logic signed [15:0] cos_limit_q;
	logic [23:0]        residual_limit_q;
	dp_cmd_t            cmd;
	dp_stat_t           stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= 11'd640;
			frame_height_q <= 11'd480;
			half_window_q <= 2'd2;
			cos_limit_q <= 16'sd15826;
			residual_limit_q <= 24'd1024;
		end else if (cfg_valid) begin
			unique case (cfg_data.index)
				REG_FRAME_WIDTH:    frame_width_q <= cfg_data.data[10:0];
				REG_FRAME_HEIGHT:   frame_height_q <= cfg_data.data[10:0];
				REG_HALF_WINDOW:    half_window_q <= cfg_data.data[1:0];
				REG_COS_LIMIT:      cos_limit_q <= signed'(cfg_data.data[15:0]);
				REG_RESIDUAL_LIMIT: residual_limit_q <= cfg_data.data;
				default: ;
			endcase
		end
	end

	wncm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .frame_start(in_data.frame_start),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_data),
		.frame_width(frame_width_q), .frame_height(frame_height_q),
		.half_window(half_window_q), .cmd(cmd), .stat(stat)
	);

	wncm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .pix(in_data),
		.cos_limit(cos_limit_q), .residual_limit(residual_limit_q), .stat(stat)
	);
endmodule

// ===== tb/window_normal_cull_mask_tb.sv =====
// ----------------------------------------------------------------------------
// window_normal_cull_mask_tb
// Drives point map pixels through the cull mask block under several frame
// sizes, window sizes and limits, with random idling on both channels.
// A local model of the raster, the line stores and the window test predicts
// every decision, and each output beat is compared against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module window_normal_cull_mask_tb;
	import wncm_pkg::*;

	typedef struct {
		bit fs;
		int px, py, pz;
		int nx, ny, nz;
		bit known;
		bit cull;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	cfg_beat_t cfg_data;

	window_normal_cull_mask dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	logic [10:0]        cfg_width;
	logic [10:0]        cfg_height;
	logic [1:0]         cfg_half;
	logic signed [15:0] cfg_cos;
	logic [23:0]        cfg_resid;
	int unsigned        rast_row;
	int unsigned        rast_col;
	in_item_t           line_mem [0:LINE_ROWS-1][0:MAX_WIDTH-1];

	out_item_t decision_q[$];
	int        mismatches = 0;
	bit        send_idle = 0;
	bit        recv_idle = 0;
	int        idle_pct = 78;
	bit        hold_req = 0;
	bit        hold = 0;
	int        base_px, base_py, base_pz;
	int        base_nx, base_ny, base_nz;

	stim_row_t directed[] = '{
		'{1, 0, 0, 0, 16384, 0, 0, 1, 1},
		'{0, 8388607, 8388607, 8388607, 16384, 0, 0, 1, 0},
		'{0, -8388608, -8388608, -8388608, -16384, 0, 0, 1, 0},
		'{0, 1, 0, 0, 0, 0, 0, 1, 1},
		'{0, 0, 0, 1, 0, 0, -16384, 1, 0},
		'{0, 7, -3, 2, 16384, 16384, 16384, 1, 0},
		'{0, 7, 3, 2, -32768, 0, 0, 1, 0},
		'{0, -1, 3, 2, 32767, -32768, 0, 1, 0},
		'{0, 9, 9, 9, 100, 0, 0, 1, 1},
		'{0, 9, 9, 9, 16383, 0, 0, 1, 0},
		'{0, 9, 9, 9, 15000, 0, 0, 1, 1},
		'{1, 5, 5, 5, 0, 16384, 0, 1, 0},
		'{0, 4, -4, 100, 1234, -5678, 9012, 0, 0},
		'{0, -77, 0, 3, -16384, 16384, -16384, 0, 0},
		'{0, 0, 0, -1, 0, 0, 16384, 0, 0},
		'{0, 0, 0, 0, 0, 0, 0, 1, 1},
		'{0, 12, 34, 56, 0, -16384, 0, 0, 0}
	};

	always #5 clk = ~clk;

	initial begin
		#10ms;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= !(hold || (recv_idle && $urandom_range(99) < idle_pct));
	end

	always begin
		wait (hold_req);
		@(posedge clk);
		hold <= 1'b1;
		repeat (600) @(posedge clk);
		hold <= 1'b0;
		hold_req = 0;
	end

	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && out_ready) begin
			if (decision_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat row %0d col %0d culled %0d",
						out_data.center_row, out_data.center_col, out_data.culled);
			end else begin
				want = decision_q.pop_front();
				if (out_data.center_row !== want.center_row
						|| out_data.center_col !== want.center_col
						|| out_data.culled !== want.culled) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
							want.center_row, want.center_col, want.culled,
							out_data.center_row, out_data.center_col, out_data.culled);
				end
			end
		end
	end

	function automatic bit decide_pixel(input in_item_t px, output out_item_t res);
		int unsigned w, hgt, h, row, col, rr, ck;
		in_item_t    seed, nb;
		longint      snx, sny, snz, dot, offs, cos_q28, res_lim;
		bit          cull, emit;
		w = (cfg_width < 1) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
		hgt = (cfg_height < 1) ? 1 : (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
		h = cfg_half;
		emit = 0;
		res = '0;
		if (px.frame_start) begin
			rast_row = 0;
			rast_col = 0;
		end
		if (rast_col >= w) begin
			rast_col = 0;
			rast_row++;
		end
		if (rast_row >= hgt)
			rast_row = 0;
		row = rast_row;
		col = rast_col;
		line_mem[row % LINE_ROWS][col] = px;
		if (row >= 2 * h && col >= 2 * h) begin
			seed = line_mem[(row - h) % LINE_ROWS][col - h];
			snx = longint'($signed(seed.norm_x));
			sny = longint'($signed(seed.norm_y));
			snz = longint'($signed(seed.norm_z));
			cos_q28 = longint'(cfg_cos) * 16384;
			res_lim = longint'(cfg_resid) * 16384;
			cull = 0;
			if (seed.pos_x == 0 && seed.pos_y == 0 && seed.pos_z == 0) begin
				cull = 1;
			end else begin
				for (rr = row - 2 * h; rr <= row; rr++) begin
					for (ck = col - 2 * h; ck <= col; ck++) begin
						nb = line_mem[rr % LINE_ROWS][ck];
						dot = snx * $signed(nb.norm_x) + sny * $signed(nb.norm_y)
							+ snz * $signed(nb.norm_z);
						offs = snx * (longint'(seed.pos_x) - longint'(nb.pos_x))
							+ sny * (longint'(seed.pos_y) - longint'(nb.pos_y))
							+ snz * (longint'(seed.pos_z) - longint'(nb.pos_z));
						if (offs < 0)
							offs = -offs;
						if (dot < (longint'(1) << 28) && dot < cos_q28)
							cull = 1;
						if (offs > res_lim)
							cull = 1;
					end
				end
			end
			res.center_row = 10'(row - h);
			res.center_col = 10'(col - h);
			res.culled = cull;
			emit = 1;
		end
		rast_col++;
		if (rast_col >= w) begin
			rast_col = 0;
			rast_row++;
			if (rast_row >= hgt)
				rast_row = 0;
		end
		return emit;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input int unsigned value);
		cfg_valid <= 1'b1;
		cfg_data <= '{index: idx, data: 24'(value)};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH: cfg_width = 11'(value);
			REG_FRAME_HEIGHT: cfg_height = 11'(value);
			REG_HALF_WINDOW: cfg_half = 2'(value);
			REG_COS_LIMIT: cfg_cos = 16'(value);
			REG_RESIDUAL_LIMIT: cfg_resid = 24'(value);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_pixel(input in_item_t px, input bit known, input bit cull);
		out_item_t res;
		in_valid <= 1'b1;
		in_data <= px;
		do @(posedge clk); while (!in_ready);
		if (decide_pixel(px, res)) begin
			if (known)
				res.culled = cull;
			decision_q.push_back(res);
		end
		if (send_idle && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (decision_q.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	function automatic in_item_t make_pixel(input bit first);
		in_item_t px;
		int       pick;
		pick = $urandom_range(99);
		if (pick < 72) begin
			px.pos_x = 24'(base_px + $urandom_range(8) - 4);
			px.pos_y = 24'(base_py + $urandom_range(8) - 4);
			px.pos_z = 24'(base_pz + $urandom_range(8) - 4);
			px.norm_x = 16'(base_nx + $urandom_range(80) - 40);
			px.norm_y = 16'(base_ny + $urandom_range(80) - 40);
			px.norm_z = 16'(base_nz + $urandom_range(80) - 40);
		end else if (pick < 76) begin
			px.pos_x = '0;
			px.pos_y = '0;
			px.pos_z = '0;
			px.norm_x = 16'(base_nx);
			px.norm_y = 16'(base_ny);
			px.norm_z = 16'(base_nz);
		end else if (pick < 88) begin
			px.pos_x = 24'(base_px);
			px.pos_y = 24'(base_py);
			px.pos_z = 24'(base_pz);
			px.norm_x = 16'(-base_nx);
			px.norm_y = 16'(-base_ny + $urandom_range(4000));
			px.norm_z = 16'($urandom_range(32768) - 16384);
		end else begin
			px.pos_x = 24'($urandom);
			px.pos_y = 24'($urandom);
			px.pos_z = 24'($urandom);
			px.norm_x = 16'($urandom);
			px.norm_y = 16'($urandom);
			px.norm_z = 16'($urandom);
		end
		px.frame_start = first || ($urandom_range(99) < 2);
		return px;
	endfunction

	task automatic run_phase(input int unsigned w, input int unsigned hgt,
			input int unsigned h, input int unsigned cos, input int unsigned resid,
			input int count, input bit s_idle, input bit r_idle);
		int axis;
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, hgt);
		write_reg(REG_HALF_WINDOW, h);
		write_reg(REG_COS_LIMIT, cos);
		write_reg(REG_RESIDUAL_LIMIT, resid);
		idle_pct = (s_idle && r_idle) ? 33 : 78;
		send_idle = s_idle;
		recv_idle = r_idle;
		base_px = $urandom_range(200000) - 100000;
		base_py = $urandom_range(200000) - 100000;
		base_pz = $urandom_range(200000) + 1;
		axis = $urandom_range(2);
		base_nx = (axis == 0) ? 16384 : 0;
		base_ny = (axis == 1) ? 16384 : 0;
		base_nz = (axis == 2) ? 16384 : 0;
		if ($urandom_range(1)) begin
			base_nx = -base_nx;
			base_ny = -base_ny;
			base_nz = -base_nz;
		end
		for (int i = 0; i < count; i++)
			send_pixel(make_pixel(i == 0), 1'b0, 1'b0);
		drain();
	endtask

	initial begin
		in_item_t px;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		cfg_width = 11'd640;
		cfg_height = 11'd480;
		cfg_half = 2'd2;
		cfg_cos = 16'sd15826;
		cfg_resid = 24'd1024;
		rast_row = 0;
		rast_col = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_FRAME_WIDTH, 5);
		write_reg(REG_FRAME_HEIGHT, 3);
		write_reg(REG_HALF_WINDOW, 0);
		foreach (directed[i]) begin
			px.frame_start = directed[i].fs;
			px.pos_x = 24'(directed[i].px);
			px.pos_y = 24'(directed[i].py);
			px.pos_z = 24'(directed[i].pz);
			px.norm_x = 16'(directed[i].nx);
			px.norm_y = 16'(directed[i].ny);
			px.norm_z = 16'(directed[i].nz);
			send_pixel(px, directed[i].known, directed[i].cull);
		end
		drain();

		run_phase(1, 1024, 1, 15826, 1024, 30, 1, 0);
		run_phase(0, 0, 0, 16'hC000, 1024, 30, 0, 1);
		run_phase(12, 10, 1, 15826, 64, 300, 1, 1);
		run_phase(2047, 5, 0, 16384, 0, 60, 0, 0);
		run_phase(9, 9, 3, 16000, 24'hFFFFFF, 250, 1, 0);
		hold_req = 1;
		run_phase(16, 12, 2, $urandom_range(32768) - 16384,
			$urandom_range(100000), 300, 0, 1);
		run_phase(8, 8, 1, 14000, 200, 100, 0, 0);
		wait (decision_q.size() == 0);
		run_phase(8, 8, 1, 14000, 200, 100, 1, 1);

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
